### hw/rtl/hbcd_pkg.sv
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared types and constants for the HTTP body chunked decoder.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  localparam int unsigned MAX_SIZE_DIGITS = 8;
  localparam int unsigned DIGIT_CNT_W     = 4;

  localparam logic [31:0] BODY_LIMIT_RESET = 32'h0010_0000;

  // body framing modes
  localparam logic [1:0] MODE_CLOSE   = 2'd0;
  localparam logic [1:0] MODE_LENGTH  = 2'd1;
  localparam logic [1:0] MODE_CHUNKED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BODY_MODE      = 2'd0;
  localparam logic [1:0] CFG_CONTENT_LENGTH = 2'd1;
  localparam logic [1:0] CFG_BODY_LIMIT     = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_LARGE = 2'd1,
    ERR_BAD_SIZE  = 2'd2
  } err_code_t;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_EXT      = 3'd1,
    PH_DATA     = 3'd2,
    PH_DATA_END = 3'd3,
    PH_TRAILER  = 3'd4
  } chunk_phase_t;

  typedef struct packed {
    chunk_phase_t             phase;
    logic [31:0]              chunk_rem;
    logic [DIGIT_CNT_W-1:0]   digit_cnt;
    logic                     trailer_nonempty;
    logic [31:0]              body_count;
    logic                     done;
    logic                     failed;
    logic                     truncated;
    err_code_t                err;
  } dec_state_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       done;
    logic       failed;
    logic       truncated;
    err_code_t  err;
  } dec_result_t;

endpackage

### hw/rtl/hbcd_step.sv
// ----------------------------------------------------------------------------
// hbcd_step
// One-byte update of the decoder state and the matching result beat.
// ----------------------------------------------------------------------------
module hbcd_step (
  input  logic [1:0]          body_mode,
  input  logic [31:0]         content_length,
  input  logic [31:0]         body_limit,
  input  logic [7:0]          in_byte,
  input  logic                is_eof,
  input  hbcd_pkg::dec_state_t  st,
  output hbcd_pkg::dec_state_t  st_nxt,
  output hbcd_pkg::dec_result_t res
);

  logic        is_hex;
  logic [3:0]  hex_val;
  logic [7:0]  lc;
  logic        under_limit;
  logic        take_req;
  logic        take_ok;
  logic [31:0] count_inc;

  // character decode and limit check
  always_comb begin
    lc      = (in_byte inside {[8'h41:8'h5A]}) ? (in_byte | 8'h20) : in_byte;
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h30);
    end else if (lc inside {[8'h61:8'h66]}) begin
      is_hex  = 1'b1;
      hex_val = 4'(lc - 8'h57);
    end
    under_limit = (st.body_count < body_limit);
    count_inc   = st.body_count + 32'd1;
  end

  // next state
  always_comb begin
    st_nxt   = st;
    take_req = 1'b0;
    if (!st.done && !st.failed) begin
      if (is_eof) begin
        if (body_mode == hbcd_pkg::MODE_CHUNKED ||
            (body_mode == hbcd_pkg::MODE_LENGTH && st.body_count < content_length)) begin
          st_nxt.truncated = 1'b1;
        end
        st_nxt.done = 1'b1;
      end else if (body_mode == hbcd_pkg::MODE_CHUNKED) begin
        case (st.phase)
          hbcd_pkg::PH_EXT: begin
            if (in_byte == hbcd_pkg::CH_LF) begin
              st_nxt.phase = (st.chunk_rem != 32'd0) ? hbcd_pkg::PH_DATA : hbcd_pkg::PH_TRAILER;
              st_nxt.trailer_nonempty = 1'b0;
            end
          end
          hbcd_pkg::PH_DATA: begin
            take_req         = 1'b1;
            st_nxt.chunk_rem = st.chunk_rem - 32'd1;
            if (st.chunk_rem == 32'd1) begin
              st_nxt.phase = hbcd_pkg::PH_DATA_END;
            end
          end
          hbcd_pkg::PH_DATA_END: begin
            if (in_byte == hbcd_pkg::CH_LF) begin
              st_nxt.phase     = hbcd_pkg::PH_SIZE;
              st_nxt.chunk_rem = 32'd0;
              st_nxt.digit_cnt = '0;
            end
          end
          hbcd_pkg::PH_TRAILER: begin
            if (in_byte == hbcd_pkg::CH_LF) begin
              if (!st.trailer_nonempty) begin
                st_nxt.done = 1'b1;
              end
              st_nxt.trailer_nonempty = 1'b0;
            end else if (in_byte != hbcd_pkg::CH_CR) begin
              st_nxt.trailer_nonempty = 1'b1;
            end
          end
          default: begin
            // size line
            if (is_hex) begin
              if (st.digit_cnt >= hbcd_pkg::DIGIT_CNT_W'(hbcd_pkg::MAX_SIZE_DIGITS)) begin
                st_nxt.failed = 1'b1;
                st_nxt.err    = hbcd_pkg::ERR_TOO_LARGE;
              end else begin
                st_nxt.digit_cnt = st.digit_cnt + 1'b1;
                st_nxt.chunk_rem = {st.chunk_rem[27:0], hex_val};
              end
            end else if (in_byte == hbcd_pkg::CH_LF) begin
              if (st.digit_cnt == '0) begin
                st_nxt.failed = 1'b1;
                st_nxt.err    = hbcd_pkg::ERR_BAD_SIZE;
              end else begin
                st_nxt.phase = (st.chunk_rem != 32'd0) ? hbcd_pkg::PH_DATA
                                                       : hbcd_pkg::PH_TRAILER;
                st_nxt.trailer_nonempty = 1'b0;
              end
            end else if (in_byte == hbcd_pkg::CH_SEMI || in_byte == hbcd_pkg::CH_SP ||
                         in_byte == hbcd_pkg::CH_TAB) begin
              st_nxt.phase = hbcd_pkg::PH_EXT;
            end else if (in_byte != hbcd_pkg::CH_CR) begin
              st_nxt.failed = 1'b1;
              st_nxt.err    = hbcd_pkg::ERR_BAD_SIZE;
            end
          end
        endcase
      end else if (body_mode == hbcd_pkg::MODE_LENGTH) begin
        if (st.body_count < content_length) begin
          take_req = 1'b1;
          if (under_limit && count_inc >= content_length) begin
            st_nxt.done = 1'b1;
          end
        end else begin
          st_nxt.done = 1'b1;
        end
      end else begin
        take_req = 1'b1;
      end

      // byte delivery against the body limit
      if (take_req) begin
        if (under_limit) begin
          st_nxt.body_count = count_inc;
        end else begin
          st_nxt.truncated = 1'b1;
          st_nxt.done      = 1'b1;
        end
      end
    end
  end

  assign take_ok = take_req && under_limit;

  // result beat
  always_comb begin
    res.body_valid = take_ok;
    res.body_byte  = take_ok ? in_byte : 8'd0;
    res.done       = st_nxt.done;
    res.failed     = st_nxt.failed;
    res.truncated  = st_nxt.truncated;
    res.err        = st_nxt.err;
  end

endmodule

### hw/rtl/http_body_chunked_decoder_top.sv
// ----------------------------------------------------------------------------
// http_body_chunked_decoder_top
// Decodes an HTTP response body, one stream byte per beat, into body bytes.
// ----------------------------------------------------------------------------
// Feed the body stream after the response head, one byte per input beat; each
// input beat yields exactly one output beat in the following cycle, carrying an
// optional body byte (out_tuser high) and the sticky done, failed, truncated
// and error status. Framing follows body_mode: read until close, content
// length, or chunked with hex size lines, extensions, trailers and a blank
// trailer line as the end. A beat with in_tuser high marks connection close.
// Throughput is one beat per clock: all per-byte work is a single pass through
// the step logic into the state and result registers, and a new beat is taken
// whenever the result register is empty or being drained in the same cycle.
// Configuration writes are single-cycle and must only happen while idle.
module http_body_chunked_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] is_eof
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] body_byte, [8] done_res, [9] failed,
                                  // [10] truncated, [12:11] error_code, rest 0
  output logic        out_tuser   // [0] body_valid
);

  // configuration registers
  logic [1:0]  body_mode_r;
  logic [31:0] content_length_r;
  logic [31:0] body_limit_r;

  // decoder state and result register
  hbcd_pkg::dec_state_t  state_r;
  hbcd_pkg::dec_state_t  state_nxt;
  hbcd_pkg::dec_result_t res_nxt;
  hbcd_pkg::dec_result_t res_r;
  logic                  out_valid_r;

  logic in_fire;

  // accept while the result slot is free or draining this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r      <= hbcd_pkg::MODE_CLOSE;
      content_length_r <= 32'd0;
      body_limit_r     <= hbcd_pkg::BODY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hbcd_pkg::CFG_BODY_MODE:      body_mode_r      <= cfg_wdata[1:0];
        hbcd_pkg::CFG_CONTENT_LENGTH: content_length_r <= cfg_wdata;
        hbcd_pkg::CFG_BODY_LIMIT:     body_limit_r     <= cfg_wdata;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  hbcd_step u_step (
    .body_mode      (body_mode_r),
    .content_length (content_length_r),
    .body_limit     (body_limit_r),
    .in_byte        (in_tdata),
    .is_eof         (in_tuser),
    .st             (state_r),
    .st_nxt         (state_nxt),
    .res            (res_nxt)
  );

  // state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= hbcd_pkg::PH_SIZE;
      state_r.chunk_rem        <= 32'd0;
      state_r.digit_cnt        <= '0;
      state_r.trailer_nonempty <= 1'b0;
      state_r.body_count       <= 32'd0;
      state_r.done             <= 1'b0;
      state_r.failed           <= 1'b0;
      state_r.truncated        <= 1'b0;
      state_r.err              <= hbcd_pkg::ERR_NONE;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register, payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.body_valid;
  assign out_tdata  = {3'b000, res_r.err, res_r.truncated, res_r.failed,
                       res_r.done, res_r.body_byte};

`ifndef ASSERT_OFF
  // a framing error always carries a code
  a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.failed |-> state_r.err != hbcd_pkg::ERR_NONE)
    else $error("failed set without error code");

  // done and failed never coexist: each stops further processing
  a_done_xor_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.done && state_r.failed))
    else $error("done and failed both set");

  // completion is sticky
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.done |=> state_r.done)
    else $error("done flag cleared");

  // a beat taken after completion delivers no body byte
  a_no_byte_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r.done |=> out_tvalid && !out_tuser)
    else $error("body byte delivered after done");
`endif

endmodule

### tb/hbcd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbcd_result_checker
// Watches the decoder's channels, predicts every result beat from the
// accepted input beats and the live register values, and compares.
// ----------------------------------------------------------------------------
module hbcd_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          delivered,
  output int          checked
);

  // register copies
  logic [1:0]             cur_mode;
  logic [31:0]            cur_clen;
  logic [31:0]            cur_limit;

  // decoder state copy
  hbcd_pkg::chunk_phase_t           ph;
  logic [31:0]                      chunk_left;
  logic [hbcd_pkg::DIGIT_CNT_W-1:0] digits;
  logic                             trailer_text;
  logic [31:0]                      body_cnt;
  logic                             st_done;
  logic                             st_failed;
  logic                             st_trunc;
  hbcd_pkg::err_code_t              st_err;

  hbcd_pkg::dec_result_t  expected_results[$];
  hbcd_pkg::dec_result_t  want;
  int                     mismatches = 0;
  int                     checked_n  = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    $display("mismatch at result %0d: %s is %0h, predicted %0h",
             checked_n, what, got, exp_val);
  endtask

  function automatic void fail_with(input hbcd_pkg::err_code_t code);
    if (!st_failed) begin
      st_failed = 1'b1;
      st_err    = code;
    end
  endfunction

  // hand one body byte on, unless the limit is hit
  function automatic void deliver(input logic [7:0] b, inout hbcd_pkg::dec_result_t r);
    if (st_done) return;
    if ({1'b0, body_cnt} + 33'd1 > {1'b0, cur_limit}) begin
      st_trunc = 1'b1;
      st_done  = 1'b1;
      return;
    end
    r.body_valid = 1'b1;
    r.body_byte  = b;
    body_cnt     = body_cnt + 32'd1;
  endfunction

  function automatic void close_size_line();
    if (chunk_left != 32'd0) ph = hbcd_pkg::PH_DATA;
    else ph = hbcd_pkg::PH_TRAILER;
    trailer_text = 1'b0;
  endfunction

  function automatic void chunk_step(input logic [7:0] c, inout hbcd_pkg::dec_result_t r);
    logic [7:0] lc;
    logic [3:0] nib;
    logic       hex;
    case (ph)
      hbcd_pkg::PH_EXT: begin
        if (c == hbcd_pkg::CH_LF) close_size_line();
      end
      hbcd_pkg::PH_DATA: begin
        deliver(c, r);
        chunk_left = chunk_left - 32'd1;
        if (chunk_left == 32'd0) ph = hbcd_pkg::PH_DATA_END;
      end
      hbcd_pkg::PH_DATA_END: begin
        // anything up to the line feed is skipped
        if (c == hbcd_pkg::CH_LF) begin
          ph         = hbcd_pkg::PH_SIZE;
          chunk_left = 32'd0;
          digits     = '0;
        end
      end
      hbcd_pkg::PH_TRAILER: begin
        if (c == hbcd_pkg::CH_LF) begin
          if (!trailer_text) st_done = 1'b1;
          trailer_text = 1'b0;
        end else if (c != hbcd_pkg::CH_CR) begin
          trailer_text = 1'b1;
        end
      end
      default: begin
        lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        hex = 1'b1;
        nib = 4'd0;
        if (c >= "0" && c <= "9") nib = 4'(c - "0");
        else if (lc >= "a" && lc <= "f") nib = 4'(lc - "a" + 8'd10);
        else hex = 1'b0;
        if (hex) begin
          if (digits >= hbcd_pkg::MAX_SIZE_DIGITS) begin
            fail_with(hbcd_pkg::ERR_TOO_LARGE);
          end else begin
            digits     = digits + 1'b1;
            chunk_left = (chunk_left << 4) + 32'(nib);
          end
        end else if (c == hbcd_pkg::CH_LF) begin
          if (digits == 0) fail_with(hbcd_pkg::ERR_BAD_SIZE);
          else close_size_line();
        end else if (c == hbcd_pkg::CH_SEMI || c == hbcd_pkg::CH_SP ||
                     c == hbcd_pkg::CH_TAB) begin
          ph = hbcd_pkg::PH_EXT;
        end else if (c != hbcd_pkg::CH_CR) begin
          fail_with(hbcd_pkg::ERR_BAD_SIZE);
        end
      end
    endcase
  endfunction

  function automatic hbcd_pkg::dec_result_t decode_beat(input logic [7:0] c,
                                                        input logic eof);
    hbcd_pkg::dec_result_t r;
    r = '0;
    if (!st_done && !st_failed) begin
      if (eof) begin
        if (cur_mode == hbcd_pkg::MODE_CHUNKED ||
            (cur_mode == hbcd_pkg::MODE_LENGTH && body_cnt < cur_clen))
          st_trunc = 1'b1;
        st_done = 1'b1;
      end else if (cur_mode == hbcd_pkg::MODE_CHUNKED) begin
        chunk_step(c, r);
      end else if (cur_mode == hbcd_pkg::MODE_LENGTH) begin
        if (body_cnt < cur_clen) deliver(c, r);
        if (body_cnt >= cur_clen) st_done = 1'b1;
      end else begin
        deliver(c, r);
      end
    end
    r.done      = st_done;
    r.failed    = st_failed;
    r.truncated = st_trunc;
    r.err       = st_err;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode     = hbcd_pkg::MODE_CLOSE;
      cur_clen     = 32'd0;
      cur_limit    = hbcd_pkg::BODY_LIMIT_RESET;
      ph           = hbcd_pkg::PH_SIZE;
      chunk_left   = 32'd0;
      digits       = '0;
      trailer_text = 1'b0;
      body_cnt     = 32'd0;
      st_done      = 1'b0;
      st_failed    = 1'b0;
      st_trunc     = 1'b0;
      st_err       = hbcd_pkg::ERR_NONE;
      expected_results.delete();
    end else begin
      // drain first: a result leaving now belongs to an earlier beat
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 32'(out_tdata), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.body_valid)
            report_mismatch("body_valid", 32'(out_tuser), 32'(want.body_valid));
          if (out_tdata[7:0] !== want.body_byte)
            report_mismatch("body_byte", 32'(out_tdata[7:0]), 32'(want.body_byte));
          if (out_tdata[8] !== want.done)
            report_mismatch("done", 32'(out_tdata[8]), 32'(want.done));
          if (out_tdata[9] !== want.failed)
            report_mismatch("failed", 32'(out_tdata[9]), 32'(want.failed));
          if (out_tdata[10] !== want.truncated)
            report_mismatch("truncated", 32'(out_tdata[10]), 32'(want.truncated));
          if (out_tdata[12:11] !== want.err)
            report_mismatch("error_code", 32'(out_tdata[12:11]), 32'(want.err));
          if (out_tdata[15:13] !== 3'b000)
            report_mismatch("padding bits", 32'(out_tdata[15:13]), 32'd0);
        end
        checked_n++;
      end
      if (cfg_we) begin
        case (cfg_index)
          hbcd_pkg::CFG_BODY_MODE:      cur_mode  = cfg_wdata[1:0];
          hbcd_pkg::CFG_CONTENT_LENGTH: cur_clen  = cfg_wdata;
          hbcd_pkg::CFG_BODY_LIMIT:     cur_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(decode_beat(in_tdata, in_tuser));
    end
    pending   <= expected_results.size();
    delivered <= body_cnt;
    checked   <= checked_n;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HTTP body chunked decoder: directed beats over
// all framings, then a long well-formed chunked stream with mode switches,
// random idling on both sides, and one randomly chosen way of ending the body.
// ----------------------------------------------------------------------------
module tb;

  localparam int          RANDOM_BEATS = 800;
  localparam int          HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int          QUIET_LIMIT  = 5000;  // watchdog: cycles with no beat
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;  // behaves as read until close

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = hbcd_pkg::CFG_BODY_MODE;
  logic [31:0] cfg_wdata  = 32'd0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  int chk_fails;
  int chk_pending;
  int chk_delivered;
  int chk_checked;

  // register values the stimulus last wrote
  logic [1:0]  mode_r  = hbcd_pkg::MODE_CLOSE;
  logic [31:0] clen_r  = 32'd0;
  logic [31:0] limit_r = hbcd_pkg::BODY_LIMIT_RESET;

  // idling knobs, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // bumping press_seq asks the receiver for one long hold-off
  int press_seq  = 0;
  int press_seen = 0;
  int hold_left  = 0;
  bit pressed    = 1'b0;
  bit press_now  = 1'b0;

  int          beats_sent     = 0;
  int          directed_beats = 0;
  int          quiet_cycles   = 0;
  int          scenario;
  int unsigned n_data;
  string       ending;

  http_body_chunked_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tuser   (in_tuser),    // [0] is_eof
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] body_byte, [8] done, [9] failed,
                               // [10] truncated, [12:11] error_code
    .out_tuser  (out_tuser)    // [0] body_valid
  );

  hbcd_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (chk_fails),
    .pending    (chk_pending),
    .delivered  (chk_delivered),
    .checked    (chk_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stalls, plus one long hold-off on request so the
  // result register fills and the decoder has to push back on its input
  always @(posedge clk) begin
    if (press_seq != press_seen) begin
      press_seen <= press_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: a run with no beat for too long is hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, chk_pending);
      $display("status: fail");
      $finish;
    end
  end

  // offer one beat, with random idle cycles in front of it; valid stays up
  // across back-to-back beats
  task automatic send_beat(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_crlf();
    send_beat(hbcd_pkg::CH_CR, 1'b0);
    send_beat(hbcd_pkg::CH_LF, 1'b0);
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // write all three registers from mode_r, clen_r and limit_r
  task automatic program_regs();
    cfg_we    <= 1'b1;
    cfg_index <= hbcd_pkg::CFG_BODY_MODE;
    cfg_wdata <= {30'd0, mode_r};
    @(posedge clk);
    cfg_index <= hbcd_pkg::CFG_CONTENT_LENGTH;
    cfg_wdata <= clen_r;
    @(posedge clk);
    cfg_index <= hbcd_pkg::CFG_BODY_LIMIT;
    cfg_wdata <= limit_r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    if (upper) return 8'h41 + {4'd0, v} - 8'd10;
    return 8'h61 + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == hbcd_pkg::CH_LF) b = 8'($urandom);
    return b;
  endfunction

  // one well-formed chunk: size line (random case, leading zeros, stray CRs,
  // maybe an extension), n data bytes, then the line end after the data
  task automatic send_chunk(input int unsigned n);
    int          sig;
    int          lead;
    int unsigned rest;
    sig  = 0;
    rest = n;
    while (rest != 0) begin
      sig++;
      rest = rest >> 4;
    end
    lead = ($urandom_range(3) == 0) ? $urandom_range(hbcd_pkg::MAX_SIZE_DIGITS - sig) : 0;
    repeat (lead) send_beat("0", 1'b0);
    for (int i = sig - 1; i >= 0; i--) begin
      send_beat(hex_char(4'(n >> (4 * i)), 1'($urandom)), 1'b0);
      if ($urandom_range(9) == 0) send_beat(hbcd_pkg::CH_CR, 1'b0);
    end
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0:       send_beat(hbcd_pkg::CH_SEMI, 1'b0);
        1:       send_beat(hbcd_pkg::CH_SP, 1'b0);
        default: send_beat(hbcd_pkg::CH_TAB, 1'b0);
      endcase
      repeat ($urandom_range(6)) send_beat(any_but_lf(), 1'b0);
    end
    if ($urandom_range(4) != 0) send_beat(hbcd_pkg::CH_CR, 1'b0);
    send_beat(hbcd_pkg::CH_LF, 1'b0);
    repeat (n) send_beat(8'($urandom), 1'b0);
    // junk ahead of the line feed is skipped unchecked
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) send_beat(any_but_lf(), 1'b0);
    if ($urandom_range(4) != 0) send_beat(hbcd_pkg::CH_CR, 1'b0);
    send_beat(hbcd_pkg::CH_LF, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset framing is read until close: byte extremes go straight through
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    // unused mode code, widest limits
    wait_idle();
    mode_r  = MODE_UNUSED;
    clen_r  = 32'hFFFF_FFFF;
    limit_r = 32'hFFFF_FFFF;
    program_regs();
    send_beat(hbcd_pkg::CH_LF, 1'b0);
    send_beat(hbcd_pkg::CH_CR, 1'b0);
    // content length far away
    wait_idle();
    mode_r = hbcd_pkg::MODE_LENGTH;
    program_regs();
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b0);
    // chunked: exactly the digit limit, extension by space, one data byte
    wait_idle();
    mode_r = hbcd_pkg::MODE_CHUNKED;
    program_regs();
    send_str("00000001");
    send_beat(hbcd_pkg::CH_SP, 1'b0);
    send_crlf();
    send_beat(8'hA5, 1'b0);
    send_crlf();
    directed_beats = beats_sent;

    // ---- random part: chunked stream, now and then another framing ----
    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      case (((beats_sent - directed_beats) / 100) % 5)
        1: begin
          send_idle_pct  = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 73;
        end
        3: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      press_now = 1'b0;
      if (!pressed && beats_sent >= directed_beats + 300) begin
        pressed   = 1'b1;
        press_now = 1'b1;
        press_seq++;
      end
      // during the hold-off the sender keeps offering chunk beats
      if (press_now || $urandom_range(99) < 88) begin
        n_data = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_chunk(n_data);
      end else begin
        // between chunks: a few beats under another framing, then back;
        // the chunk state is kept across the switch
        wait_idle();
        case ($urandom_range(2))
          0: mode_r = hbcd_pkg::MODE_CLOSE;
          1: mode_r = MODE_UNUSED;
          default: begin
            mode_r = hbcd_pkg::MODE_LENGTH;
            clen_r = $urandom_range(1) ? 32'hFFFF_FFFF : chk_delivered + 2000;
          end
        endcase
        case ($urandom_range(2))
          0:       limit_r = 32'hFFFF_FFFF;
          1:       limit_r = hbcd_pkg::BODY_LIMIT_RESET;
          default: limit_r = chk_delivered + 3000;
        endcase
        program_regs();
        repeat ($urandom_range(1, 10)) send_beat(8'($urandom), 1'b0);
        wait_idle();
        mode_r = hbcd_pkg::MODE_CHUNKED;
        program_regs();
      end
    end

    // ---- one way of ending the body; the flags are sticky after it ----
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    wait_idle();
    scenario = $urandom_range(10);
    case (scenario)
      0: begin
        ending = "last chunk, one trailer line, blank line";
        send_str("0");
        send_crlf();
        send_str("X-Check: 1");
        send_crlf();
        send_crlf();
      end
      1: begin
        ending = "digitless size line via extension, then blank line";
        send_beat(hbcd_pkg::CH_SEMI, 1'b0);
        send_str("last");
        send_crlf();
        send_beat(hbcd_pkg::CH_LF, 1'b0);
      end
      2: begin
        ending = "close in the middle of the largest chunk";
        send_str("FFFFFFFF");
        send_crlf();
        repeat (5) send_beat(8'($urandom), 1'b0);
        send_beat(8'h00, 1'b1);
      end
      3: begin
        ending = "size digit past the limit";
        send_str("000000001");
      end
      4: begin
        ending = "non-hex byte in the size line";
        send_str("1g");
      end
      5: begin
        ending = "size line with no digits";
        send_crlf();
      end
      6: begin
        ending = "content length reached";
        mode_r = hbcd_pkg::MODE_LENGTH;
        clen_r = chk_delivered + $urandom_range(0, 4);
        program_regs();
        repeat (6) send_beat(8'($urandom), 1'b0);
      end
      7: begin
        ending  = "body limit reached";
        mode_r  = hbcd_pkg::MODE_CLOSE;
        limit_r = $urandom_range(1) ? 32'd0 : chk_delivered + $urandom_range(0, 4);
        program_regs();
        repeat (8) send_beat(8'($urandom), 1'b0);
      end
      8: begin
        ending = "close before the content length";
        mode_r = hbcd_pkg::MODE_LENGTH;
        clen_r = chk_delivered + 100;
        program_regs();
        repeat (3) send_beat(8'($urandom), 1'b0);
        send_beat(8'hFF, 1'b1);
      end
      9: begin
        ending = "close while reading until close";
        mode_r = $urandom_range(1) ? hbcd_pkg::MODE_CLOSE : MODE_UNUSED;
        program_regs();
        repeat (3) send_beat(8'($urandom), 1'b0);
        send_beat(8'h00, 1'b1);
      end
      default: begin
        ending = "zero content length";
        mode_r = hbcd_pkg::MODE_LENGTH;
        clen_r = 32'd0;
        program_regs();
        send_beat(8'($urandom), 1'b0);
      end
    endcase
    // everything after the end is ignored, close included
    send_beat(8'hFF, 1'b1);
    repeat (20) send_beat(8'($urandom), 1'($urandom));

    // ---- wind down ----
    wait_idle();
    repeat (4) @(posedge clk);
    $display("covered %0d input beats (%0d directed), %0d results, %0d body bytes",
             beats_sent, directed_beats, chk_checked, chk_delivered);
    $display("body ended by: %s", ending);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
